@@ design/lir_pkg.sv @@
// shared constants for the linear interpolation resampler
`default_nettype none

package lir_pkg;

  // default sizing of the block
  localparam int unsigned MAX_RUN_DEF     = 32;
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned RATE_BITS_DEF   = 18;

  // result buffer for one input beat
  localparam int unsigned RES_CAP = 64;
  localparam int unsigned RES_AW  = $clog2(RES_CAP);
  localparam int unsigned RES_NW  = $clog2(RES_CAP + 1);

  // rate registers come out of reset at this value
  localparam int unsigned RATE_RESET = 24000;

  // configuration register indexes
  localparam int unsigned CFG_IW = 1;
  localparam logic [CFG_IW-1:0] CFG_SOURCE_RATE = 1'b0;
  localparam logic [CFG_IW-1:0] CFG_TARGET_RATE = 1'b1;

endpackage

`default_nettype wire

@@ design/linear_interp_resampler.sv @@
// top level of the linear interpolation sample rate converter
`default_nettype none

// Linear interpolation resampler. Output positions are tracked exactly as a pair
// offset and a remainder against target_rate; each interpolated value costs a pass
// through the test state, one bit-serial multiply and one bit-serial divide. After
// the outputs of a pair, the phase update takes one or two further divides, and a
// pair that is skipped takes none. The results of one input beat are collected in
// a 64-entry buffer and then shown one at a time, each read out and then held
// until out_ready_i. A held output adds one more divide, and the final beat of a
// stream adds a pass through the final test state per repeat of its sample. A new
// beat is taken only once every result of the previous one has been delivered.
// Rate registers are written through a plain write port; the user must write them
// only while the block is idle, as the block itself does not enforce it; a rate of
// zero is treated as one.

module linear_interp_resampler
  import lir_pkg::*;
#(
  parameter int unsigned MAX_RUN     = MAX_RUN_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int unsigned RATE_BITS   = RATE_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [SAMPLE_BITS-1:0] sample_in_i,
  input  wire logic                   stream_last_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [SAMPLE_BITS-1:0]      sample_out_o,
  output logic                        run_last_o,
  output logic                        stream_end_o,
  output logic                        run_overflow_o,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IW-1:0]      cfg_idx_i,
  input  wire logic [RATE_BITS-1:0]   cfg_data_i
);

  localparam int unsigned SB = SAMPLE_BITS;
  localparam int unsigned RB = RATE_BITS;
  localparam int unsigned DW = SB + RB;
  localparam int unsigned JW = $clog2(MAX_RUN + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PTEST,
    S_MUL,
    S_DIV,
    S_HCNT,
    S_PHASE,
    S_TOT,
    S_OFF,
    S_FINAL,
    S_FTEST,
    S_CLEAR,
    S_OUT,
    S_RD,
    S_SHOW
  } state_e;

  state_e state_q, state_d;

  logic [RB-1:0]     src_q, src_d;
  logic [RB-1:0]     tgt_q, tgt_d;
  logic [SB-1:0]     prev_q, prev_d;
  logic              prev_valid_q, prev_valid_d;
  logic [RB-1:0]     skip_q, skip_d;
  logic [RB-1:0]     phase_q, phase_d;
  logic              hold_valid_q, hold_valid_d;
  logic [SB-1:0]     hold_value_q, hold_value_d;
  logic [RB-1:0]     hold_count_q, hold_count_d;
  logic [SB-1:0]     cur_q, cur_d;
  logic              last_q, last_d;
  logic [RB:0]       r_q, r_d;
  logic [JW-1:0]     j_q, j_d;
  logic              hold_mode_q, hold_mode_d;
  logic [RES_NW-1:0] res_n_q, res_n_d;
  logic              ovf_q, ovf_d;
  logic [RES_NW-1:0] rd_idx_q, rd_idx_d;
  logic              out_valid_q, out_valid_d;
  logic              run_last_q, run_last_d;
  logic              stream_end_q, stream_end_d;
  logic              run_ovf_q, run_ovf_d;
  logic [SB-1:0]     out_sample_q;

  logic [SB-1:0]     mem_q [RES_CAP];

  // effective rates and phase arithmetic
  logic [RB-1:0]     fr;
  logic [RB-1:0]     to;
  logic [RB+1:0]     to_x2;
  logic [RB+1:0]     to_x3;
  logic [RB+1:0]     rf;
  logic [RB-1:0]     hc;
  logic [RB:0]       tot_v;
  logic [RB:0]       off_m1;
  logic [DW-1:0]     hold_num;

  // interpolation datapath
  logic [SB:0]       d_ext;
  logic              d_neg;
  logic [SB:0]       d_abs;
  logic [SB:0]       q_signed;
  logic [SB:0]       v_ext;
  logic [SB-1:0]     lerp_v;

  logic              mul_start;
  logic              mul_done;
  logic [DW-1:0]     mul_prod;
  logic              div_start;
  logic [DW-1:0]     div_num;
  logic [RB-1:0]     div_den;
  logic              div_done;
  logic [DW-1:0]     div_quot;
  logic [RB-1:0]     div_rem;

  logic              push_en;
  logic [SB-1:0]     push_data;
  logic              wr_en;
  logic [RES_AW-1:0] wr_addr;

  assign fr    = (src_q == '0) ? RB'(1) : src_q;
  assign to    = (tgt_q == '0) ? RB'(1) : tgt_q;
  assign to_x2 = {1'b0, to, 1'b0};
  assign to_x3 = to_x2 + {2'b00, to};
  assign rf    = {1'b0, r_q} + {2'b00, fr};
  assign hc    = (hold_count_q != '0) ? hold_count_q - RB'(1) : hold_count_q;

  // first position past the target rate, from the remainder of (to - r0) / fr
  assign tot_v  = (div_rem == '0) ? {1'b0, to}
                                  : {1'b0, to} + {1'b0, fr} - {1'b0, div_rem};
  assign off_m1 = div_quot[RB:0] - (RB+1)'(1);
  // ceil((r + fr) / to) as a floor division
  assign hold_num = DW'(rf) + DW'(to) - DW'(1);

  // lerp: prev + sign(d) * (|d| * r / to), truncated toward zero
  assign d_ext    = {cur_q[SB-1], cur_q} - {prev_q[SB-1], prev_q};
  assign d_neg    = d_ext[SB];
  assign d_abs    = d_neg ? (~d_ext + (SB+1)'(1)) : d_ext;
  assign q_signed = d_neg ? (~{1'b0, div_quot[SB-1:0]} + (SB+1)'(1))
                          : {1'b0, div_quot[SB-1:0]};
  assign v_ext    = {prev_q[SB-1], prev_q} + q_signed;
  assign lerp_v   = v_ext[SB-1:0];

  lir_mul #(
    .A_BITS(SB),
    .B_BITS(RB)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (d_abs[SB-1:0]),
    .b_i    (r_q[RB-1:0]),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  lir_div #(
    .N_BITS(DW),
    .D_BITS(RB)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_num),
    .divisor_i (div_den),
    .done_o    (div_done),
    .quot_o    (div_quot),
    .rem_o     (div_rem)
  );

  always_comb begin
    state_d      = state_q;
    src_d        = src_q;
    tgt_d        = tgt_q;
    prev_d       = prev_q;
    prev_valid_d = prev_valid_q;
    skip_d       = skip_q;
    phase_d      = phase_q;
    hold_valid_d = hold_valid_q;
    hold_value_d = hold_value_q;
    hold_count_d = hold_count_q;
    cur_d        = cur_q;
    last_d       = last_q;
    r_d          = r_q;
    j_d          = j_q;
    hold_mode_d  = hold_mode_q;
    res_n_d      = res_n_q;
    ovf_d        = ovf_q;
    rd_idx_d     = rd_idx_q;
    out_valid_d  = out_valid_q;
    run_last_d   = run_last_q;
    stream_end_d = stream_end_q;
    run_ovf_d    = run_ovf_q;
    mul_start    = 1'b0;
    div_start    = 1'b0;
    div_num      = '0;
    div_den      = to;
    push_en      = 1'b0;
    push_data    = hold_value_q;
    wr_en        = 1'b0;
    wr_addr      = '0;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SOURCE_RATE: src_d = cfg_data_i;
        CFG_TARGET_RATE: tgt_d = cfg_data_i;
        default:         src_d = src_q;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cur_d   = sample_in_i;
          last_d  = stream_last_i;
          res_n_d = '0;
          ovf_d   = 1'b0;
          // a held output is released or dropped once enough samples are seen
          if (hold_valid_q) begin
            hold_count_d = hc;
            if (stream_last_i) begin
              push_en      = (hc == '0);
              hold_valid_d = 1'b0;
            end else if (hc <= RB'(1)) begin
              push_en      = 1'b1;
              hold_valid_d = 1'b0;
            end
          end
          if (prev_valid_q) begin
            if (skip_q != '0) begin
              skip_d  = skip_q - RB'(1);
              state_d = S_FINAL;
            end else begin
              r_d     = {1'b0, phase_q};
              j_d     = '0;
              state_d = S_PTEST;
            end
          end else begin
            state_d = S_FINAL;
          end
        end
      end
      S_PTEST: begin
        if (r_q >= {1'b0, to}) begin
          state_d = S_PHASE;
        end else if (last_q && (rf > to_x2)) begin
          state_d = S_PHASE;
        end else if (!last_q && (rf > to_x3)) begin
          mul_start   = 1'b1;
          hold_mode_d = 1'b1;
          state_d     = S_MUL;
        end else if (j_q >= JW'(MAX_RUN)) begin
          ovf_d   = 1'b1;
          state_d = S_PHASE;
        end else begin
          mul_start   = 1'b1;
          hold_mode_d = 1'b0;
          state_d     = S_MUL;
        end
      end
      S_MUL: begin
        if (mul_done) begin
          div_start = 1'b1;
          div_num   = mul_prod;
          div_den   = to;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (!hold_mode_q) begin
            push_en   = 1'b1;
            push_data = lerp_v;
            j_d       = j_q + JW'(1);
            r_d       = rf[RB:0];
            state_d   = S_PTEST;
          end else begin
            // a still pending held output goes out before the new one is held
            push_en      = hold_valid_q;
            hold_value_d = lerp_v;
            hold_valid_d = 1'b1;
            div_start    = 1'b1;
            div_num      = hold_num;
            div_den      = to;
            state_d      = S_HCNT;
          end
        end
      end
      S_HCNT: begin
        if (div_done) begin
          hold_count_d = div_quot[RB-1:0] - RB'(2);
          state_d      = S_PHASE;
        end
      end
      S_PHASE: begin
        div_start = 1'b1;
        if (r_q >= {1'b0, to}) begin
          div_num = DW'(r_q);
          div_den = to;
          state_d = S_OFF;
        end else begin
          div_num = DW'({1'b0, to} - {1'b0, phase_q});
          div_den = fr;
          state_d = S_TOT;
        end
      end
      S_TOT: begin
        if (div_done) begin
          div_start = 1'b1;
          div_num   = DW'(tot_v);
          div_den   = to;
          state_d   = S_OFF;
        end
      end
      S_OFF: begin
        if (div_done) begin
          phase_d = div_rem;
          skip_d  = (div_quot == '0) ? '0 : off_m1[RB-1:0];
          state_d = S_FINAL;
        end
      end
      S_FINAL: begin
        if (last_q) begin
          if (skip_q == '0) begin
            r_d     = {1'b0, phase_q};
            j_d     = '0;
            state_d = S_FTEST;
          end else begin
            state_d = S_CLEAR;
          end
        end else begin
          prev_d       = cur_q;
          prev_valid_d = 1'b1;
          state_d      = S_OUT;
        end
      end
      S_FTEST: begin
        // repeats of the final sample up to the end of the stream
        if (rf > {2'b00, to}) begin
          state_d = S_CLEAR;
        end else if (j_q >= JW'(MAX_RUN)) begin
          ovf_d   = 1'b1;
          state_d = S_CLEAR;
        end else begin
          push_en   = 1'b1;
          push_data = cur_q;
          j_d       = j_q + JW'(1);
          r_d       = rf[RB:0];
        end
      end
      S_CLEAR: begin
        prev_d       = '0;
        prev_valid_d = 1'b0;
        skip_d       = '0;
        phase_d      = '0;
        hold_valid_d = 1'b0;
        hold_value_d = '0;
        hold_count_d = '0;
        state_d      = S_OUT;
      end
      S_OUT: begin
        rd_idx_d = '0;
        state_d  = (res_n_q == '0) ? S_IDLE : S_RD;
      end
      S_RD: begin
        run_last_d   = (rd_idx_q == res_n_q - RES_NW'(1));
        stream_end_d = (rd_idx_q == res_n_q - RES_NW'(1)) && last_q;
        run_ovf_d    = ovf_q;
        out_valid_d  = 1'b1;
        state_d      = S_SHOW;
      end
      S_SHOW: begin
        if (out_ready_i) begin
          out_valid_d = 1'b0;
          if (rd_idx_q + RES_NW'(1) == res_n_q) begin
            state_d = S_IDLE;
          end else begin
            rd_idx_d = rd_idx_q + RES_NW'(1);
            state_d  = S_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    // result buffer append, overflow past its capacity
    if (push_en) begin
      if (res_n_d < RES_NW'(RES_CAP)) begin
        wr_en   = 1'b1;
        wr_addr = res_n_d[RES_AW-1:0];
        res_n_d = res_n_d + RES_NW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      src_q        <= RB'(RATE_RESET);
      tgt_q        <= RB'(RATE_RESET);
      prev_q       <= '0;
      prev_valid_q <= 1'b0;
      skip_q       <= '0;
      phase_q      <= '0;
      hold_valid_q <= 1'b0;
      hold_value_q <= '0;
      hold_count_q <= '0;
      cur_q        <= '0;
      last_q       <= 1'b0;
      r_q          <= '0;
      j_q          <= '0;
      hold_mode_q  <= 1'b0;
      res_n_q      <= '0;
      ovf_q        <= 1'b0;
      rd_idx_q     <= '0;
      out_valid_q  <= 1'b0;
      run_last_q   <= 1'b0;
      stream_end_q <= 1'b0;
      run_ovf_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      src_q        <= src_d;
      tgt_q        <= tgt_d;
      prev_q       <= prev_d;
      prev_valid_q <= prev_valid_d;
      skip_q       <= skip_d;
      phase_q      <= phase_d;
      hold_valid_q <= hold_valid_d;
      hold_value_q <= hold_value_d;
      hold_count_q <= hold_count_d;
      cur_q        <= cur_d;
      last_q       <= last_d;
      r_q          <= r_d;
      j_q          <= j_d;
      hold_mode_q  <= hold_mode_d;
      res_n_q      <= res_n_d;
      ovf_q        <= ovf_d;
      rd_idx_q     <= rd_idx_d;
      out_valid_q  <= out_valid_d;
      run_last_q   <= run_last_d;
      stream_end_q <= stream_end_d;
      run_ovf_q    <= run_ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= push_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_RD) begin
      out_sample_q <= mem_q[rd_idx_q[RES_AW-1:0]];
    end
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign sample_out_o   = out_sample_q;
  assign run_last_o     = run_last_q;
  assign stream_end_o   = stream_end_q;
  assign run_overflow_o = run_ovf_q;

  // input and output sides never overlap within one beat's processing
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_o && in_ready_o))
    else $error("result shown while a new input beat is taken");

  a_res_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_n_q <= RES_NW'(RES_CAP))
    else $error("result count past buffer capacity");

  a_run_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    j_q <= JW'(MAX_RUN))
    else $error("run counter past its limit");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("ready held after an accepted beat");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD) |-> (rd_idx_q < res_n_q))
    else $error("result read beyond the filled part of the buffer");

endmodule

`default_nettype wire

@@ design/lir_mul.sv @@
// bit-serial unsigned shift-add multiplier, one multiplier bit per cycle
`default_nettype none

module lir_mul
  import lir_pkg::*;
#(
  parameter int unsigned A_BITS = SAMPLE_BITS_DEF,
  parameter int unsigned B_BITS = RATE_BITS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [A_BITS-1:0]          a_i,
  input  wire logic [B_BITS-1:0]          b_i,
  output logic                            done_o,
  output logic [A_BITS+B_BITS-1:0]        prod_o
);

  localparam int unsigned P_BITS = A_BITS + B_BITS;
  localparam int unsigned CW     = $clog2(B_BITS + 1);

  logic [A_BITS-1:0] a_q;
  logic [B_BITS-1:0] b_q;
  logic [P_BITS-1:0] acc_q;
  logic [CW-1:0]     cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [P_BITS-1:0] addend;

  // msb first: shift the partial sum, add the multiplicand when the bit is set
  assign addend = b_q[B_BITS-1] ? {{B_BITS{1'b0}}, a_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(B_BITS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= {acc_q[P_BITS-2:0], 1'b0} + addend;
      b_q   <= {b_q[B_BITS-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

`default_nettype wire

@@ design/lir_div.sv @@
// bit-serial restoring divider, one quotient bit per cycle
`default_nettype none

module lir_div
  import lir_pkg::*;
#(
  parameter int unsigned N_BITS = SAMPLE_BITS_DEF + RATE_BITS_DEF,
  parameter int unsigned D_BITS = RATE_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [N_BITS-1:0] dividend_i,
  input  wire logic [D_BITS-1:0] divisor_i,
  output logic                   done_o,
  output logic [N_BITS-1:0]      quot_o,
  output logic [D_BITS-1:0]      rem_o
);

  localparam int unsigned CW = $clog2(N_BITS + 1);

  logic [N_BITS-1:0] quot_q;
  logic [D_BITS-1:0] rem_q;
  logic [D_BITS-1:0] den_q;
  logic [CW-1:0]     cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [D_BITS:0]   trial;
  logic [D_BITS:0]   diff;
  logic              ge;

  // the dividend shifts out of the top of quot_q as quotient bits shift in
  assign trial = {rem_q, quot_q[N_BITS-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(N_BITS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      den_q  <= divisor_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[N_BITS-2:0], ge};
      rem_q  <= ge ? diff[D_BITS-1:0] : trial[D_BITS-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire
